FILE: hw/rtl/zncc_patch_match_weight_core_defines.svh
// assertion helpers shared by the rtl
`ifndef ZNCC_PATCH_MATCH_WEIGHT_CORE_DEFINES_SVH
`define ZNCC_PATCH_MATCH_WEIGHT_CORE_DEFINES_SVH

// same-cycle implication
`define ZPMW_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ZPMW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/zpmw_pkg.sv
package zpmw_pkg;

   localparam int PATCH_RADIUS_DEF = 3;
   localparam int NPIX_W = 8;
   localparam int SUM_W = 16;
   localparam int SQ_W = 24;
   localparam int SCORE_W = 18;
   localparam int WEIGHT_W = 8;
   localparam int SCALE_W = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd20;
   localparam logic [SCORE_W-1:0] SCORE_ONE = 18'sd65536;
   localparam logic [SCORE_W-1:0] SCORE_MINUS_ONE = -18'sd65536;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   typedef struct packed {
      logic [SQ_W-1:0]  sum_cross;
      logic [SQ_W-1:0]  sumsq_right;
      logic [SQ_W-1:0]  sumsq_left;
      logic [SUM_W-1:0] sum_right;
      logic [SUM_W-1:0] sum_left;
   } patch_sums_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIFF,
      BK_PROD,
      BK_ROOT1,
      BK_DIV,
      BK_SCORE,
      BK_ROOT2,
      BK_WEIGHT,
      BK_OUT
   } back_state_type;

endpackage

FILE: hw/rtl/zpmw_front.sv
module zpmw_front #(
   parameter int NPIX = 49
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [zpmw_pkg::REQ_DATA_W-1:0] req_tdata,
   input  zpmw_pkg::queue_stat_type q_stat,
   output logic                    push,
   output zpmw_pkg::patch_sums_type push_data
);
   import zpmw_pkg::*;

   localparam int CNT_W = $clog2(NPIX);

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   patch_sums_type acc_ff, acc_in;
   logic [7:0] pl, pr;
   logic accept, last;

   assign pl = req_tdata[7:0];
   assign pr = req_tdata[15:8];
   assign req_tready = !q_stat.full;
   assign accept = req_tvalid && req_tready;
   assign last = (cnt_ff == CNT_W'(NPIX - 1));

   always_comb begin
      acc_in.sum_left    = acc_ff.sum_left + SUM_W'(pl);
      acc_in.sum_right   = acc_ff.sum_right + SUM_W'(pr);
      acc_in.sumsq_left  = acc_ff.sumsq_left + SQ_W'(16'(pl) * 16'(pl));
      acc_in.sumsq_right = acc_ff.sumsq_right + SQ_W'(16'(pr) * 16'(pr));
      acc_in.sum_cross   = acc_ff.sum_cross + SQ_W'(16'(pl) * 16'(pr));
      cnt_in = last ? '0 : cnt_ff + 1'b1;
   end

   assign push = accept && last;
   assign push_data = acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         acc_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         acc_ff <= last ? '0 : acc_in;
      end
   end

endmodule

FILE: hw/rtl/zpmw_queue.sv
module zpmw_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  zpmw_pkg::patch_sums_type push_data,
   input  logic                     pop,
   output zpmw_pkg::patch_sums_type pop_data,
   output zpmw_pkg::queue_stat_type q_stat
);
   import zpmw_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   patch_sums_type mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, rd_ff;
   logic [PTR_W:0] cnt_ff;
   logic do_push, do_pop;

   assign q_stat.full = (cnt_ff == (PTR_W+1)'(QUEUE_DEPTH));
   assign q_stat.empty = (cnt_ff == '0);
   assign do_push = push && !q_stat.full;
   assign do_pop = pop && !q_stat.empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hw/rtl/zpmw_back.sv
module zpmw_back #(
   parameter int NPIX = 49
) (
   input  logic                     clock,
   input  logic                     reset,
   input  zpmw_pkg::queue_stat_type q_stat,
   input  zpmw_pkg::patch_sums_type pop_data,
   output logic                     pop,
   input  logic [zpmw_pkg::SCALE_W-1:0] weight_scale,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [zpmw_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import zpmw_pkg::*;

   localparam logic [NPIX_W-1:0] N_CONST = NPIX_W'(NPIX);

   back_state_type state_ff, state_in;
   patch_sums_type sums_ff, sums_in;
   logic [2:0] step_ff, step_in;
   logic [31:0] p_ff [6];
   logic [33:0] vl_ff, vr_ff, cv_ff, vl_in, vr_in, cv_in;
   logic flat_ff, flat_in;
   logic [63:0] sv_ff, sv_in;
   logic [34:0] srem_ff, srem_in, srem_shift, strial;
   logic [31:0] sres_ff, sres_in;
   logic [5:0] scnt_ff, scnt_in;
   logic [31:0] den_ff, den_in, mag_ff, mag_in;
   logic [48:0] drem_ff, drem_in, dsr_ff, dsr_in;
   logic [16:0] q_ff, q_in;
   logic [SCORE_W-1:0] score_ff, score_in;
   logic [WEIGHT_W-1:0] weight_ff, weight_in;
   logic out_valid_ff, out_valid_in;
   logic [SCORE_W-1:0] out_score_ff, out_score_in;
   logic [WEIGHT_W-1:0] out_weight_ff, out_weight_in;
   logic [23:0] ma, mb;
   logic [31:0] mprod;
   logic [63:0] prod64;
   logic [24:0] wprod;
   logic [16:0] qc;
   logic [16:0] root_arg;
   logic p_wr;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - SCORE_W - WEIGHT_W){1'b0}}, out_weight_ff, out_score_ff};

   // shared operand mux for the six moment products
   always_comb begin
      case (step_ff)
         3'd0: begin ma = SQ_W'(N_CONST); mb = sums_ff.sumsq_left; end
         3'd1: begin ma = SQ_W'(sums_ff.sum_left); mb = SQ_W'(sums_ff.sum_left); end
         3'd2: begin ma = SQ_W'(N_CONST); mb = sums_ff.sumsq_right; end
         3'd3: begin ma = SQ_W'(sums_ff.sum_right); mb = SQ_W'(sums_ff.sum_right); end
         3'd4: begin ma = SQ_W'(N_CONST); mb = sums_ff.sum_cross; end
         3'd5: begin ma = SQ_W'(sums_ff.sum_left); mb = SQ_W'(sums_ff.sum_right); end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign mprod = 32'(ma) * 32'(mb);
   assign p_wr = (state_ff == BK_MUL);

   assign prod64 = vl_ff[31:0] * vr_ff[31:0];
   assign wprod = 25'(weight_scale) * 25'(score_ff[16:0]);

   // one root bit per cycle
   assign srem_shift = {srem_ff[32:0], sv_ff[63:62]};
   assign strial = {1'b0, sres_ff, 2'b01};

   assign qc = (q_ff > 17'd65536) ? 17'd65536 : q_ff;
   // one minus score, the score being zero for a flat patch
   assign root_arg = flat_ff ? 17'd65536 : 17'd65536 - qc;

   always_comb begin
      state_in = state_ff;
      sums_in = sums_ff;
      step_in = step_ff;
      vl_in = vl_ff;
      vr_in = vr_ff;
      cv_in = cv_ff;
      flat_in = flat_ff;
      sv_in = sv_ff;
      srem_in = srem_ff;
      sres_in = sres_ff;
      scnt_in = scnt_ff;
      den_in = den_ff;
      mag_in = mag_ff;
      drem_in = drem_ff;
      dsr_in = dsr_ff;
      q_in = q_ff;
      score_in = score_ff;
      weight_in = weight_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_score_in = out_score_ff;
      out_weight_in = out_weight_ff;
      pop = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty) begin
               pop = 1'b1;
               sums_in = pop_data;
               step_in = '0;
               state_in = BK_MUL;
            end
         end
         BK_MUL: begin
            step_in = step_ff + 1'b1;
            if (step_ff == 3'd5) begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF: begin
            vl_in = {2'b00, p_ff[0]} - {2'b00, p_ff[1]};
            vr_in = {2'b00, p_ff[2]} - {2'b00, p_ff[3]};
            cv_in = {2'b00, p_ff[4]} - {2'b00, p_ff[5]};
            state_in = BK_PROD;
         end
         BK_PROD: begin
            flat_in = vl_ff[33] || (vl_ff == '0) || vr_ff[33] || (vr_ff == '0);
            mag_in = cv_ff[33] ? 32'(-cv_ff) : cv_ff[31:0];
            sv_in = prod64;
            srem_in = '0;
            sres_in = '0;
            scnt_in = 6'd32;
            state_in = BK_ROOT1;
         end
         BK_ROOT1, BK_ROOT2: begin
            sv_in = {sv_ff[61:0], 2'b00};
            if (srem_shift >= strial) begin
               srem_in = srem_shift - strial;
               sres_in = {sres_ff[30:0], 1'b1};
            end else begin
               srem_in = srem_shift;
               sres_in = {sres_ff[30:0], 1'b0};
            end
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == 6'd1) begin
               if (state_ff == BK_ROOT1) begin
                  den_in = (sres_in == '0) ? 32'd1 : sres_in;
                  drem_in = {1'b0, mag_ff, 16'd0} + 49'(den_in[31:1]);
                  dsr_in = {1'b0, den_in, 16'd0};
                  q_in = '0;
                  scnt_in = 6'd17;
                  state_in = BK_DIV;
               end else begin
                  score_in = SCORE_W'(sres_in[16:0]);
                  state_in = BK_WEIGHT;
               end
            end
         end
         BK_DIV: begin
            if (drem_ff >= dsr_ff) begin
               drem_in = drem_ff - dsr_ff;
               q_in = {q_ff[15:0], 1'b1};
            end else begin
               q_in = {q_ff[15:0], 1'b0};
            end
            dsr_in = {1'b0, dsr_ff[48:1]};
            scnt_in = scnt_ff - 1'b1;
            if (scnt_ff == 6'd1) begin
               state_in = BK_SCORE;
            end
         end
         BK_SCORE: begin
            if (flat_ff) begin
               score_in = '0;
            end else if (cv_ff[33]) begin
               score_in = SCORE_W'(-$signed({1'b0, qc}));
            end else begin
               score_in = SCORE_W'(qc);
            end
            if (!flat_ff && cv_ff[33] && (qc != '0)) begin
               weight_in = weight_scale;
               state_in = BK_OUT;
            end else begin
               // reuse score_ff to hold the root result, keep score aside
               out_score_in = out_score_ff;
               // 17 root steps take the top 34 bits: (1 - score) << 16 sits there
               sv_in = {1'b0, root_arg, 46'd0};
               srem_in = '0;
               sres_in = '0;
               scnt_in = 6'd17;
               state_in = BK_ROOT2;
            end
            mag_in = {14'd0, score_in};
         end
         BK_WEIGHT: begin
            weight_in = 8'(({7'd0, wprod} + 32'd32768) >> 16);
            score_in = mag_ff[SCORE_W-1:0];
            state_in = BK_OUT;
         end
         BK_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_valid_in = 1'b1;
               out_score_in = (state_ff == BK_OUT) ? score_ff : out_score_ff;
               out_weight_in = weight_ff;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (p_wr) begin
         p_ff[step_ff] <= mprod;
      end
      sums_ff <= sums_in;
      step_ff <= step_in;
      vl_ff <= vl_in;
      vr_ff <= vr_in;
      cv_ff <= cv_in;
      flat_ff <= flat_in;
      sv_ff <= sv_in;
      srem_ff <= srem_in;
      sres_ff <= sres_in;
      scnt_ff <= scnt_in;
      den_ff <= den_in;
      mag_ff <= mag_in;
      drem_ff <= drem_in;
      dsr_ff <= dsr_in;
      q_ff <= q_in;
      score_ff <= score_in;
      weight_ff <= weight_in;
      out_score_ff <= out_score_in;
      out_weight_ff <= out_weight_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

FILE: hw/rtl/zncc_patch_match_weight_core.sv
// after the last pixel pair of a patch the back end runs 6 products, a 32-step root,
// a 17-step divide, a 17-step root and the weight; a nonzero negative score skips that root and the weight
// throughput: one pixel pair per cycle while the 2-entry queue has room; the back end
// takes one patch at a time and pops the next one from the queue only when back in idle
// reset (synchronous, active high) clears accumulators, queue and rsp_tvalid;
// weight_scale returns to 20
`include "zncc_patch_match_weight_core_defines.svh"

module zncc_patch_match_weight_core #(
   parameter int PATCH_RADIUS = zpmw_pkg::PATCH_RADIUS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // pixel_left [7:0], pixel_right [15:8]
   input  logic [zpmw_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // match_score [17:0], match_weight [25:18], zero pad [31:26]
   output logic [zpmw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic csr_wr_en,
   input  logic [zpmw_pkg::SCALE_W-1:0] csr_wr_data
);
   import zpmw_pkg::*;

   localparam int NPIX = (2 * PATCH_RADIUS + 1) * (2 * PATCH_RADIUS + 1);

   logic [SCALE_W-1:0] scale_ff;
   queue_stat_type q_stat;
   patch_sums_type push_data, pop_data;
   logic push, pop;
   logic score_ok;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   zpmw_front #(.NPIX(NPIX)) u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_stat, .push, .push_data
   );

   zpmw_queue u_queue (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .q_stat
   );

   zpmw_back #(.NPIX(NPIX)) u_back (
      .clock, .reset, .q_stat, .pop_data, .pop,
      .weight_scale(scale_ff), .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   assign score_ok = ($signed(rsp_tdata[SCORE_W-1:0]) <= $signed(SCORE_ONE))
                     && ($signed(rsp_tdata[SCORE_W-1:0]) >= $signed(SCORE_MINUS_ONE));

   `ZPMW_ASSERT_NOW(a_no_push_full, clock, reset, push, !q_stat.full, "push into full queue")
   `ZPMW_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   `ZPMW_ASSERT_NOW(a_score_range, clock, reset, rsp_tvalid, score_ok, "score out of range")

endmodule

FILE: sim/tb_top.sv
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import zpmw_pkg::*;

   localparam int RADIUS = PATCH_RADIUS_DEF;
   localparam int SIDE = 2 * RADIUS + 1;
   localparam int NPIX = SIDE * SIDE;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [7:0] pixel_right;
      logic [7:0] pixel_left;
   } pixel_pair_type;

   typedef struct {
      logic signed [SCORE_W-1:0] score;
      logic [WEIGHT_W-1:0] weight;
   } match_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_wr_en = 1'b0;
   logic [SCALE_W-1:0] csr_wr_data = '0;

   zncc_patch_match_weight_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   pixel_pair_type pending_pixels[$];
   match_type expected_matches[$];
   int error_count = 0;

   // predictor state
   logic [7:0] scale_reg;
   logic [7:0] acc_count;
   logic [15:0] acc_sum_l, acc_sum_r;
   logic [23:0] acc_sq_l, acc_sq_r, acc_cross;

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void clear_sums();
      acc_count = 0; acc_sum_l = 0; acc_sum_r = 0;
      acc_sq_l = 0; acc_sq_r = 0; acc_cross = 0;
   endfunction

   // run the zncc math on one pixel pair, queue a match at the end of a patch
   function automatic void predict_pixel(pixel_pair_type p);
      longint sl, sr, vl, vr, cv, sc;
      longint unsigned den, mag, q, r, w;
      match_type m;
      acc_sum_l += p.pixel_left;
      acc_sum_r += p.pixel_right;
      acc_sq_l += 24'(16'(p.pixel_left) * 16'(p.pixel_left));
      acc_sq_r += 24'(16'(p.pixel_right) * 16'(p.pixel_right));
      acc_cross += 24'(16'(p.pixel_left) * 16'(p.pixel_right));
      acc_count += 1;
      if (acc_count != 8'(NPIX)) return;
      sl = acc_sum_l;
      sr = acc_sum_r;
      vl = NPIX * longint'(acc_sq_l) - sl * sl;
      vr = NPIX * longint'(acc_sq_r) - sr * sr;
      cv = NPIX * longint'(acc_cross) - sl * sr;
      if (vl <= 0 || vr <= 0) begin
         sc = 0;
      end else begin
         den = int_root(longint'(vl) * longint'(vr));
         if (den == 0) den = 1;
         mag = (cv < 0) ? -cv : cv;
         q = (mag * 65536 + den / 2) / den;
         if (q > 65536) q = 65536;
         sc = (cv < 0) ? -longint'(q) : longint'(q);
      end
      if (sc < 0) begin
         w = scale_reg;
      end else begin
         r = int_root((65536 - sc) << 16);
         w = (scale_reg * r + 32768) >> 16;
      end
      m.score = SCORE_W'(sc);
      m.weight = WEIGHT_W'(w);
      expected_matches.push_back(m);
      clear_sums();
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // driver
   int drive_gap = 0;
   bit quiet_phase = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (req_tvalid) void'(pending_pixels.pop_front());
            if (pending_pixels.size() > 0 && drive_gap == 0) begin
               req_tvalid <= 1'b1;
               req_tdata <= pending_pixels[0];
               drive_gap <= quiet_phase ? 0 : gap_len();
            end else begin
               req_tvalid <= 1'b0;
               if (drive_gap > 0) drive_gap <= drive_gap - 1;
            end
         end
      end
   end

   // monitor and response stall
   int stall = 0;
   always @(posedge clock) begin
      match_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_matches.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_tdata, 0);
            end else begin
               want = expected_matches.pop_front();
               if ($signed(rsp_tdata[17:0]) != want.score)
                  report_mismatch("match_score", $signed(rsp_tdata[17:0]), want.score);
               if (rsp_tdata[25:18] != want.weight)
                  report_mismatch("match_weight", rsp_tdata[25:18], want.weight);
            end
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall <= stall - 1;
         end else begin
            rsp_tready <= 1'b1;
            stall <= quiet_phase ? 0 : gap_len();
         end
      end
   end

   task automatic send_pixel(logic [7:0] l, logic [7:0] r);
      pixel_pair_type p;
      p.pixel_left = l;
      p.pixel_right = r;
      predict_pixel(p);
      pending_pixels.push_back(p);
   endtask

   task automatic wait_idle();
      while (pending_pixels.size() != 0 || expected_matches.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_scale(logic [7:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      scale_reg = v;
   endtask

   // one patch; mode picks the kind of content
   task automatic send_patch(int mode);
      int i;
      logic [7:0] l, r, base, off;
      base = 8'($urandom);
      off = 8'($urandom_range(0, 80));
      for (i = 0; i < NPIX; i++) begin
         l = 8'($urandom);
         case (mode)
            0: r = 8'($urandom);
            1: r = (l + off > 255) ? 8'd255 : l + off;    // strongly correlated
            2: r = 8'd255 - l;                            // anti-correlated
            3: begin l = base; r = 8'($urandom); end      // flat left patch
            4: r = 8'((l >> 1) + $urandom_range(0, 6));   // noisy correlated
            default: begin l = (i % 2) ? 8'd255 : 8'd0; r = l; end
         endcase
         send_pixel(l, r);
      end
   endtask

   initial begin
      int i, n;
      scale_reg = SCALE_RESET;
      clear_sums();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: default scale, extremes, flat, perfect, inverted
      for (i = 0; i < NPIX; i++) send_pixel(8'd0, 8'd255);
      for (i = 0; i < NPIX; i++) send_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd255 : 8'd0);
      for (i = 0; i < NPIX; i++) send_pixel(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255);
      wait_idle();

      for (n = 0; n < 4; n++) begin
         case (n)
            0: write_scale(8'd255);
            1: write_scale(8'd1);
            2: write_scale(8'd0);
            default: write_scale(8'($urandom_range(2, 254)));
         endcase
         quiet_phase = (n == 1);
         for (i = 0; i < 6; i++) send_patch(i % 6);
         wait_idle();
      end

      quiet_phase = 0;
      for (n = 0; n < 4; n++) begin
         write_scale(n == 0 ? 8'd255 : 8'($urandom_range(1, 255)));
         send_patch($urandom_range(0, 5));
         wait_idle();
      end
      // trailing partial patch never completes; accumulators keep it
      for (i = 0; i < 5; i++) send_pixel(8'($urandom), 8'($urandom));
      wait_idle();

      if (error_count == 0 && expected_matches.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hw/rtl
hw/rtl/zpmw_pkg.sv
hw/rtl/zpmw_front.sv
hw/rtl/zpmw_queue.sv
hw/rtl/zpmw_back.sv
hw/rtl/zncc_patch_match_weight_core.sv
sim/tb_top.sv
